>>> rtl/plc_pkg.sv
`default_nettype none
package plc_pkg;

  // Store geometry
  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels
  localparam int CMD_W    = 2;
  localparam int POS_W    = 16;
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_RETRIEVE = 2'd2
  } cmd_e;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic ins;  // open a slot at idx and load the new word
    logic rem;  // close the gap at idx
    logic rd;   // drive the entry at idx onto the read bus
    idx_t idx;  // zero-based target slot
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/plc_if.sv
`default_nettype none
interface plc_cmd_if;
  import plc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [POS_W-1:0]   position;
  logic [WORD_W-1:0]  item_in;

  modport source (output valid, command, position, item_in, input ready);
  modport sink   (input valid, command, position, item_in, output ready);
endinterface

interface plc_rsp_if;
  import plc_pkg::*;
  logic               valid;
  logic               ready;
  logic               success;
  logic [WORD_W-1:0]  item_out;
  logic [LEN_W-1:0]   length;

  modport source (output valid, success, item_out, length, input ready);
  modport sink   (input valid, success, item_out, length, output ready);
endinterface
`default_nettype wire

>>> rtl/plc_cell.sv
`default_nettype none
module plc_cell import plc_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire idx_t       idx_i,
  input  wire item_t      word_i,
  input  wire item_t      left_i,
  input  wire item_t      right_i,
  output item_t           q_o,
  output item_t           rd_o
);

  item_t entry_q;
  item_t entry_d;
  logic  hit;
  logic  behind;

  assign hit    = (idx_i == ctrl_i.idx);
  assign behind = (idx_i > ctrl_i.idx);

  // Take the new word, the left neighbor or the right neighbor; else hold
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && hit) begin
      entry_d = word_i;
    end else if (ctrl_i.ins && behind) begin
      entry_d = left_i;
    end else if (ctrl_i.rem && (hit || behind)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o  = entry_q;
  assign rd_o = (ctrl_i.rd && hit) ? entry_q : '0;

endmodule
`default_nettype wire

>>> rtl/positional_list_store.sv
// Results are registered; cells from the target on move in the accepting cycle.
// Throughput: one command per cycle; input ready drops only while a result
// waits unclaimed in the output register.
// Reset: asynchronous, active low; clears the entry count and the output valid.
// Entry contents are not cleared; only entries below the count are ever read.
`default_nettype none
module positional_list_store import plc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  plc_cmd_if.sink    in_i,
  plc_rsp_if.source  out_o
);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              success_q;
  logic [WORD_W-1:0] item_q;
  logic [LEN_W-1:0]  length_q;

  logic              in_fire;
  logic              pos_nz;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    cnt_ext;
  logic              ins_ok, rem_ok, rd_ok, ok;
  cell_ctrl_t        ctrl;
  item_t             word;
  item_t             cell_q  [CAPACITY];
  item_t             cell_rd [CAPACITY];
  item_t             rd_word;

  // Accept whenever the output register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign pos_nz  = (in_i.position != '0);
  assign pos_ext = (POS_W+1)'(in_i.position);
  assign cnt_ext = (POS_W+1)'(count_q);
  assign word    = ITEM_WIDTH'(in_i.item_in);

  // Decode the command against the current length
  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    rd_ok  = 1'b0;
    unique case (in_i.command)
      CMD_INSERT: begin
        ins_ok = pos_nz && (pos_ext <= cnt_ext + 1'b1)
                 && (count_q < CNT_W'(CAPACITY));
      end
      CMD_REMOVE: begin
        rem_ok = pos_nz && (pos_ext <= cnt_ext);
      end
      CMD_RETRIEVE: begin
        rd_ok = pos_nz && (pos_ext <= cnt_ext);
      end
      default: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  assign ok       = ins_ok || rem_ok || rd_ok;
  assign ctrl.ins = in_fire && ins_ok;
  assign ctrl.rem = in_fire && rem_ok;
  assign ctrl.rd  = rd_ok;
  assign ctrl.idx = IDX_W'(in_i.position - 1'b1);

  // Cell row linked to neighbors; head's left is the word, tail's right is itself
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    item_t left_w;
    item_t right_w;
    if (g == 0) begin : g_head
      assign left_w = word;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    plc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .word_i  (word),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cell_q[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Merge the read bus; at most one cell drives a nonzero word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Advance the entry count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.rem) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result of each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      success_q <= ok;
      item_q    <= WORD_W'(rd_word);
      length_q  <= LEN_W'(count_d);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.success  = success_q;
  assign out_o.item_out = item_q;
  assign out_o.length   = length_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the count");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not shrink the count");

  a_len_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_o.length == LEN_W'(count_q))
    else $error("reported length differs from count");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result stalled");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned PHASE_ITEMS = 182;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic {TREND_FILL, TREND_DRAIN} trend_e;

  typedef struct packed {
    logic              success;
    logic [WORD_W-1:0] item_out;
    logic [LEN_W-1:0]  length;
  } rsp_t;

  // Shadow list plus the queue of responses still owed by the block
  class list_tracker;
    item_t       slots [CAPACITY];
    int unsigned held;
    rsp_t        owed [$];
    int unsigned errors;
    int unsigned results;
    int unsigned successes;
    int unsigned full_refusals;

    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] word);
      rsp_t        r;
      int unsigned p;
      int          i;
      r = '{success: 1'b0, item_out: '0, length: '0};
      p = pos;
      case (cmd)
        CMD_INSERT: begin
          if (p >= 1 && p <= held + 1 && held < CAPACITY) begin
            // open a slot and move later entries back
            for (i = held; i > p - 1; i--) slots[i] = slots[i-1];
            slots[p-1] = item_t'(word);
            held++;
            r.success = 1'b1;
          end else if (p >= 1 && p <= held + 1) begin
            full_refusals++;
          end
        end
        CMD_REMOVE: begin
          if (p >= 1 && p <= held) begin
            // close the gap
            for (i = p - 1; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
            r.success = 1'b1;
          end
        end
        CMD_RETRIEVE: begin
          if (p >= 1 && p <= held) begin
            r.item_out = WORD_W'(slots[p-1]);
            r.success  = 1'b1;
          end
        end
        default: ;
      endcase
      r.length = LEN_W'(held);
      owed.push_back(r);
    endfunction

    function void check_response(logic success, logic [WORD_W-1:0] item_out,
                                 logic [LEN_W-1:0] length);
      rsp_t e;
      results++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected response success %0b item_out %h length %0d",
                 $time, success, item_out, length);
        return;
      end
      e = owed.pop_front();
      if (success !== e.success) begin
        errors++;
        $display("%0t: success expected %0b got %0b", $time, e.success, success);
      end
      if (item_out !== e.item_out) begin
        errors++;
        $display("%0t: item_out expected %h got %h", $time, e.item_out, item_out);
      end
      if (length !== e.length) begin
        errors++;
        $display("%0t: length expected %0d got %0d", $time, e.length, length);
      end
      if (success === 1'b1) successes++;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plc_cmd_if cmd_if ();
  plc_rsp_if rsp_if ();

  positional_list_store u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  list_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned sent;
  trend_e      trend;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive output ready: long hold-off first when requested, else random stalls
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Observe both channels; check responses before noting new commands
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready)
        tracker.check_response(rsp_if.success, rsp_if.item_out, rsp_if.length);
      if (cmd_if.valid && cmd_if.ready)
        tracker.note_command(cmd_if.command, cmd_if.position, cmd_if.item_in);
    end
  end

  // Offer one command, with random idle cycles ahead of it, and hold until taken
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.position <= pos;
    cmd_if.item_in  <= word;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sent++;
  endtask

  // Mostly legal positions, with zero, just past the end and wild values mixed in
  function automatic logic [POS_W-1:0] pick_position(int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80 && top >= 1) return POS_W'($urandom_range(top, 1));
    if (r < 86) return '0;
    if (r < 93) return POS_W'(top + 1);
    return POS_W'($urandom_range(65535));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Random commands that drift the length up to full and back down to empty
  task automatic run_random(input int unsigned items);
    int unsigned      r;
    int unsigned      len;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    repeat (items) begin
      len = tracker.held;
      if (trend == TREND_FILL && len == CAPACITY && $urandom_range(7) == 0)
        trend = TREND_DRAIN;
      else if (trend == TREND_DRAIN && len == 0 && $urandom_range(3) == 0)
        trend = TREND_FILL;
      r = $urandom_range(99);
      if (r < ((trend == TREND_FILL) ? 60 : 15))      cmd = CMD_INSERT;
      else if (r < ((trend == TREND_FILL) ? 75 : 60)) cmd = CMD_REMOVE;
      else if (r < 95)                                cmd = CMD_RETRIEVE;
      else                                            cmd = CMD_UNUSED;
      pos = pick_position((cmd == CMD_INSERT) ? len + 1 : len);
      send_command(cmd, pos, pick_word());
    end
  endtask

  initial begin
    int unsigned send_idle [4];
    int unsigned recv_stall [4];
    send_idle  = '{0, 83, 0, 10};
    recv_stall = '{0, 0, 83, 10};
    tracker = new();
    trend   = TREND_FILL;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_INSERT;
    cmd_if.position <= '0;
    cmd_if.item_in  <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, bounds, both word extremes, unused code
    send_command(CMD_RETRIEVE, 16'd1, '0);
    send_command(CMD_REMOVE,   16'd1, '0);
    send_command(CMD_INSERT,   16'd2, 32'h1111_1111);
    send_command(CMD_INSERT,   16'd0, 32'h2222_2222);
    send_command(CMD_INSERT,   16'd1, 32'h0000_0000);
    send_command(CMD_INSERT,   16'd2, 32'hFFFF_FFFF);
    send_command(CMD_INSERT,   16'd1, 32'hA5A5_5A5A);
    send_command(CMD_INSERT,   16'd2, 32'h1234_5678);
    send_command(CMD_INSERT,   16'd5, 32'hDEAD_BEEF);
    send_command(CMD_INSERT,   16'd7, 32'h3333_3333);
    for (int p = 1; p <= 6; p++) send_command(CMD_RETRIEVE, POS_W'(p), '1);
    send_command(CMD_RETRIEVE, 16'd0, '0);
    send_command(CMD_RETRIEVE, 16'hFFFF, '0);
    send_command(CMD_UNUSED,   16'd1, 32'h4444_4444);
    send_command(CMD_REMOVE,   16'd0, '0);
    send_command(CMD_REMOVE,   16'hFFFF, '0);
    send_command(CMD_REMOVE,   16'd3, '0);
    send_command(CMD_REMOVE,   16'd1, '0);
    send_command(CMD_RETRIEVE, 16'd2, '0);
    send_command(CMD_INSERT,   16'hFFFF, 32'h5555_5555);

    // Random phases; the first opens with a long output hold-off
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle[ph];
      recv_stall_pct = recv_stall[ph];
      if (ph == 0) hold_left = 300;
      run_random(PHASE_ITEMS);
    end

    // Drain and settle
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d commands through four idle patterns and a long output hold-off.", sent);
    $display("Checked %0d responses, %0d successful, %0d inserts refused on a full list.",
             tracker.results, tracker.successes, tracker.full_refusals);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
